FILE: design/scfl_pkg.sv
// scfl_pkg: shared types and codes for the slab chunk free list
// holds action, status and register index codes and the controller/datapath
// command and status structs; depends on nothing
package scfl_pkg;

    // request action codes
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHUNK_SHIFT     = 2'd0;
    localparam logic [1:0] CFG_CHUNK_COUNT     = 2'd1;
    localparam logic [1:0] CFG_RESERVED_CHUNKS = 2'd2;

    // configuration reset values
    localparam logic [3:0] RST_CHUNK_SHIFT     = 4'd6;
    localparam logic [8:0] RST_CHUNK_COUNT     = 9'd256;
    localparam logic [7:0] RST_RESERVED_CHUNKS = 8'd1;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic walk_step;  // write one link of the init walk
        logic commit;     // apply the request and load the response
    } scfl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic init_req;   // pending request on the input is an init
        logic init_walk;  // reserved chunks leave at least one usable chunk
        logic walk_last;  // current walk index is the last chunk
        logic out_busy;   // response register holds a result not yet taken
    } scfl_stat_t;

endpackage

FILE: design/scfl_req_if.sv
// scfl_req_if: request channel of the slab chunk free list
// valid/ready handshake carrying action and free offset; no dependencies
interface scfl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [19:0] free_offset;

    modport source (output valid, output action, output free_offset, input ready);
    modport sink   (input valid, input action, input free_offset, output ready);
endinterface

FILE: design/scfl_rsp_if.sv
// scfl_rsp_if: response channel of the slab chunk free list
// valid/ready handshake carrying status, offset, free count and flags
interface scfl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [19:0] alloc_offset;
    logic [8:0]  free_total;
    logic        slab_empty;
    logic        slab_full;

    modport source (output valid, output status, output alloc_offset,
                    output free_total, output slab_empty, output slab_full,
                    input ready);
    modport sink   (input valid, input status, input alloc_offset,
                    input free_total, input slab_empty, input slab_full,
                    output ready);
endinterface

FILE: design/scfl_cfg_if.sv
// scfl_cfg_if: configuration write channel of the slab chunk free list
// valid/ready handshake carrying register index and write data
interface scfl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/slab_chunk_free_list.sv
// Slab chunk free list: hands out and takes back equal power-of-two chunks of
// one slab through a linked free list of chunk indices in a link memory; index
// zero ends the list and the leading reserved chunks are never handed out.
// For alloc, free and the unused action, the idle state takes the request
// and reads the link memory at the list head into a register, and the done
// state then commits. Init first steps the walk state over the usable chunks,
// one link written per cycle through the single memory write
// port; usable chunks are the effective chunk count (capped at MAX_CHUNKS)
// less the effective reserved count (zero reserved acts as one), and there are
// none when the header covers the slab. The link memory is not cleared at
// reset; run init before the first alloc. Requests are taken one at a time; a
// response waits in an output register, and a finished request holds its
// commit until the previous response has been taken. Configuration writes are
// always ready and apply at once; the list is rebuilt only by the next init.
module slab_chunk_free_list
    import scfl_pkg::*;
#(
    parameter int MAX_CHUNKS  = 256,
    parameter int OFFSET_BITS = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    scfl_req_if.sink   req,
    scfl_rsp_if.source rsp,
    scfl_cfg_if.sink   cfg
);

    scfl_cmd_t  cmd;
    scfl_stat_t stat;
    logic       req_ready;

    // configuration channel never stalls
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    // sequencing
    scfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // list storage and response
    scfl_datapath #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_action       (req.action),
        .req_free_offset  (req.free_offset),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_status       (rsp.status),
        .rsp_alloc_offset (rsp.alloc_offset),
        .rsp_free_total   (rsp.free_total),
        .rsp_slab_empty   (rsp.slab_empty),
        .rsp_slab_full    (rsp.slab_full)
    );

endmodule

FILE: design/scfl_ctrl.sv
// scfl_ctrl: sequencing state machine of the slab chunk free list
// drives datapath commands from request handshake and datapath status;
// uses scfl_pkg
module scfl_ctrl
    import scfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  scfl_stat_t stat,
    output scfl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.commit    = 1'b0;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.init_req && stat.init_walk)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/scfl_datapath.sv
// scfl_datapath: link memory, list head, free tally, config and response
// registers of the slab chunk free list; acts on commands from scfl_ctrl;
// uses scfl_pkg
module scfl_datapath
    import scfl_pkg::*;
#(
    parameter int MAX_CHUNKS  = 256,
    parameter int OFFSET_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  scfl_cmd_t   cmd,
    output scfl_stat_t  stat,
    input  logic [1:0]  req_action,
    input  logic [19:0] req_free_offset,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        rsp_ready,
    output logic        rsp_valid,
    output logic [1:0]  rsp_status,
    output logic [19:0] rsp_alloc_offset,
    output logic [8:0]  rsp_free_total,
    output logic        rsp_slab_empty,
    output logic        rsp_slab_full
);

    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int TALLY_W = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W   = (TALLY_W > 9) ? TALLY_W : 9;
    localparam logic [31:0] OFF_MASK = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << OFFSET_BITS) - 64'd1);

    // configuration registers
    logic [3:0] shift_reg;
    logic [8:0] count_reg;
    logic [7:0] rsv_reg;

    // latched request
    logic [1:0]  act_reg;
    logic [19:0] foff_reg;

    // list state
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [IDX_W-1:0]   walk_idx_reg;
    logic [IDX_W-1:0]   link_rd_reg;
    logic [IDX_W-1:0]   link_mem [MAX_CHUNKS];

    // response registers
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [19:0] aoff_reg;
    logic [8:0]  total_reg;
    logic        empty_reg;
    logic        full_reg;

    logic [8:0]         count_eff;
    logic [7:0]         rsv_eff;
    logic               walk_ok;
    logic [8:0]         usable;
    logic [19:0]        free_idx;
    logic               free_bad;
    logic [31:0]        aoff_wide;
    status_t            status_next;
    logic [19:0]        aoff_next;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    logic [IDX_W-1:0]   mem_wdata;
    logic [CMP_W-1:0]   tally_x;
    logic               walk_last;

    // effective count and reserved chunks
    assign count_eff = (32'(count_reg) > 32'(MAX_CHUNKS)) ? 9'(MAX_CHUNKS) : count_reg;
    assign rsv_eff   = (rsv_reg == 8'd0) ? 8'd1 : rsv_reg;
    assign walk_ok   = {1'b0, rsv_eff} < count_eff;
    assign usable    = walk_ok ? (count_eff - {1'b0, rsv_eff}) : 9'd0;
    assign walk_last = (32'(walk_idx_reg) + 32'd1) == 32'(count_eff);

    // status to controller
    assign stat.init_req  = req_action == ACT_INIT;
    assign stat.init_walk = walk_ok;
    assign stat.walk_last = walk_last;
    assign stat.out_busy  = out_valid_reg && !rsp_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= RST_CHUNK_SHIFT;
            count_reg <= RST_CHUNK_COUNT;
            rsv_reg   <= RST_RESERVED_CHUNKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHUNK_SHIFT:     shift_reg <= cfg_data[3:0];
                CFG_CHUNK_COUNT:     count_reg <= cfg_data;
                CFG_RESERVED_CHUNKS: rsv_reg   <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // free offset to chunk index and range check
    assign free_idx  = foff_reg >> shift_reg;
    assign free_bad  = (free_idx < 20'(rsv_eff)) || (free_idx >= 20'(count_eff));
    assign aoff_wide = (32'(head_reg) << shift_reg) & OFF_MASK;

    // request outcome at commit
    always_comb
    begin
        head_next   = head_reg;
        tally_next  = tally_reg;
        status_next = ST_OK;
        aoff_next   = 20'd0;
        case (act_reg)
            ACT_INIT:
            begin
                if (walk_ok)
                begin
                    head_next  = IDX_W'(rsv_eff);
                    tally_next = TALLY_W'(usable);
                end
                else
                begin
                    head_next  = '0;
                    tally_next = '0;
                end
            end
            ACT_ALLOC:
            begin
                if (head_reg == '0)
                begin
                    status_next = ST_NO_FREE;
                end
                else
                begin
                    aoff_next = aoff_wide[19:0];
                    head_next = link_rd_reg;
                    if (tally_reg != '0)
                    begin
                        tally_next = tally_reg - 1'b1;
                    end
                end
            end
            ACT_FREE:
            begin
                if (free_bad)
                begin
                    status_next = ST_BAD_FREE;
                end
                else
                begin
                    head_next = free_idx[IDX_W-1:0];
                    if (32'(tally_reg) < 32'(MAX_CHUNKS))
                    begin
                        tally_next = tally_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // link memory write port: init walk or free push
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = walk_idx_reg;
        mem_wdata = walk_last ? '0 : walk_idx_reg + 1'b1;
        if (cmd.walk_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.commit && act_reg == ACT_FREE && !free_bad)
        begin
            mem_we    = 1'b1;
            mem_addr  = free_idx[IDX_W-1:0];
            mem_wdata = head_reg;
        end
    end

    // link memory, read at the list head when a request is taken
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            link_rd_reg <= link_mem[head_reg];
        end
    end

    // request payload and walk index
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg      <= req_action;
            foff_reg     <= req_free_offset & OFF_MASK[19:0];
            walk_idx_reg <= IDX_W'(rsv_eff);
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
    end

    // list head and free tally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tally_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            tally_reg <= tally_next;
        end
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // response payload
    assign tally_x = CMP_W'(tally_next);
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
            aoff_reg   <= aoff_next;
            total_reg  <= tally_x[8:0];
            empty_reg  <= tally_x == CMP_W'(usable);
            full_reg   <= tally_next == '0;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = status_reg;
    assign rsp_alloc_offset = aoff_reg;
    assign rsp_free_total   = total_reg;
    assign rsp_slab_empty   = empty_reg;
    assign rsp_slab_full    = full_reg;

endmodule

FILE: verif/slab_chunk_free_list_test.sv
// slab_chunk_free_list_test: self-checking testbench of the slab chunk free list
// drives init, alloc and free requests and register writes, predicts each response
// from its own free-list copy; depends on scfl_pkg, the channel interfaces and the rtl
module slab_chunk_free_list_test;
    import scfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned SLAB_MAX_CHUNKS = 256;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_PAUSE     = 4;
    localparam int END_PAUSE       = 20;
    localparam int RSP_HOLD_CYCLES = 300;

    typedef struct packed {
        status_t     status;
        logic [19:0] alloc_offset;
        logic [8:0]  free_total;
        logic        slab_empty;
        logic        slab_full;
    } slab_response_t;

    logic clk;
    logic rst_n;

    scfl_req_if req_ch();
    scfl_rsp_if rsp_ch();
    scfl_cfg_if cfg_ch();

    slab_chunk_free_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // free-list copy kept by the testbench
    logic [7:0]     next_free [0:SLAB_MAX_CHUNKS-1];
    logic [7:0]     head_chunk;
    logic [8:0]     chunks_free;
    logic [3:0]     reg_shift;
    logic [8:0]     reg_count;
    logic [7:0]     reg_reserved;

    slab_response_t awaited_responses [$];
    int unsigned    chunks_in_use [$];

    int  fault_count;
    int  responses_seen;
    int  settings_applied;
    int  action_tally [0:3];
    int  cycle_count;
    int  req_idle_pct;
    int  rsp_stall_pct;
    bit  hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // one request applied to the free-list copy; returns the response it causes
    function automatic slab_response_t advance_free_list(logic [1:0] act, logic [19:0] off);
        slab_response_t res;
        int unsigned cnt;
        int unsigned rsv;
        int unsigned usable;
        int unsigned idx;
        int unsigned i;
        cnt = (reg_count > SLAB_MAX_CHUNKS) ? SLAB_MAX_CHUNKS : reg_count;
        rsv = (reg_reserved == 0) ? 1 : reg_reserved;
        usable = (rsv < cnt) ? cnt - rsv : 0;
        res.status = ST_OK;
        res.alloc_offset = '0;
        case (act)
            ACT_INIT:
            begin
                if (rsv < cnt)
                begin
                    for (i = rsv; i + 1 < cnt; i++)
                        next_free[i] = 8'(i + 1);
                    next_free[cnt - 1] = 8'd0;
                    head_chunk = 8'(rsv);
                    chunks_free = 9'(cnt - rsv);
                end
                else
                begin
                    head_chunk = 8'd0;
                    chunks_free = 9'd0;
                end
            end
            ACT_ALLOC:
            begin
                if (head_chunk == 0)
                    res.status = ST_NO_FREE;
                else
                begin
                    res.alloc_offset = 20'(32'(head_chunk) << reg_shift);
                    head_chunk = next_free[head_chunk];
                    if (chunks_free > 0)
                        chunks_free = chunks_free - 9'd1;
                end
            end
            ACT_FREE:
            begin
                idx = 32'(off) >> reg_shift;
                if (idx < rsv || idx >= cnt)
                    res.status = ST_BAD_FREE;
                else
                begin
                    next_free[idx] = head_chunk;
                    head_chunk = 8'(idx);
                    if (chunks_free < SLAB_MAX_CHUNKS)
                        chunks_free = chunks_free + 9'd1;
                end
            end
            default:
            begin
            end
        endcase
        res.free_total = chunks_free;
        res.slab_empty = (chunks_free == usable);
        res.slab_full = (chunks_free == 0);
        return res;
    endfunction

    // one request on the request channel, predicted once it is taken
    task automatic send_request(logic [1:0] act, logic [19:0] off);
        @(negedge clk);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.free_offset <= off;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_responses.push_back(advance_free_list(act, off));
        action_tally[act]++;
    endtask

    // stop requesting and let every response come back
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [8:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_CHUNK_SHIFT:     reg_shift = value[3:0];
            CFG_CHUNK_COUNT:     reg_count = value;
            CFG_RESERVED_CHUNKS: reg_reserved = value[7:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // new slab geometry, written while the block is idle; unused high bits get noise
    task automatic apply_setting(int unsigned shift, int unsigned count, int unsigned rsv);
        wait_drained();
        write_register(CFG_CHUNK_SHIFT, 9'(($urandom_range(31) << 4) | shift));
        write_register(CFG_CHUNK_COUNT, 9'(count));
        write_register(CFG_RESERVED_CHUNKS, 9'(($urandom_range(1) << 8) | rsv));
        chunks_in_use.delete();
        settings_applied++;
    endtask

    // fixed extremes first, random geometry after, mostly small slabs
    task automatic pick_slab_setting(int seg, output int unsigned shift,
                                     output int unsigned count, output int unsigned rsv);
        int unsigned roll;
        case (seg)
            0: begin shift = 12; count = 256; rsv = 255; end
            1: begin shift = 0;  count = 511; rsv = 0;   end
            2: begin shift = 15; count = 64;  rsv = 2;   end
            3: begin shift = 1;  count = 2;   rsv = 1;   end
            4: begin shift = 6;  count = 256; rsv = 1;   end
            default:
            begin
                shift = $urandom_range(15);
                roll = $urandom_range(19);
                if (roll == 0)
                    count = $urandom_range(1);
                else if (roll < 3)
                    count = $urandom_range(41, 511);
                else
                    count = $urandom_range(2, 40);
                if (count < 2 || $urandom_range(9) == 0)
                    rsv = $urandom_range(255);
                else
                    rsv = $urandom_range(((count > 256) ? 256 : count) - 1);
            end
        endcase
    endtask

    // mostly alloc and free of chunks handed out, with bad frees, inits and noise
    task automatic issue_random_request();
        int unsigned pick;
        int unsigned cnt;
        int unsigned slot;
        int unsigned idx;
        logic [19:0] off;
        cnt = (reg_count > SLAB_MAX_CHUNKS) ? SLAB_MAX_CHUNKS : reg_count;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            chunks_in_use.delete();
            send_request(ACT_INIT, 20'($urandom));
        end
        else if (pick < 4)
            send_request(ACT_UNUSED, 20'($urandom));
        else if (pick < 12 || (pick < 55 && chunks_in_use.size() != 0))
        begin
            if (pick >= 12)
            begin
                slot = $urandom_range(chunks_in_use.size() - 1);
                idx = chunks_in_use[slot];
                chunks_in_use.delete(slot);
            end
            else
                idx = $urandom_range(cnt + 2);
            if (pick < 8)
                off = 20'($urandom);
            else
                off = 20'((idx << reg_shift) | ($urandom & ((32'd1 << reg_shift) - 1)));
            send_request(ACT_FREE, off);
        end
        else
        begin
            if (head_chunk != 0)
                chunks_in_use.push_back(head_chunk);
            send_request(ACT_ALLOC, 20'($urandom));
        end
    endtask

    // alloc on the empty list, free before init and the unused action, reset geometry
    task automatic test_reset_state();
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_UNUSED, 20'hFFFFF);
        send_request(ACT_FREE, 20'hFFFFF);
        send_request(ACT_FREE, 20'd320);
        send_request(ACT_ALLOC, 20'd0);
    endtask

    // init of the full slab, reserved and out-of-range frees, a double free
    task automatic test_init_and_recycle();
        send_request(ACT_INIT, 20'd0);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_FREE, 20'd0);
        send_request(ACT_FREE, 20'hFFFFF);
        send_request(ACT_FREE, 20'd81);
        send_request(ACT_FREE, 20'd64);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_INIT, 20'd0);
    endtask

    // one usable chunk: full, empty, and both edges of the valid range
    task automatic test_tiny_slab();
        apply_setting(1, 2, 1);
        write_register(CFG_UNUSED, 9'h1FF);
        send_request(ACT_INIT, 20'd0);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_ALLOC, 20'd0);
        send_request(ACT_FREE, 20'd3);
        send_request(ACT_FREE, 20'd4);
        send_request(ACT_FREE, 20'd1);
    endtask

    // header larger than the slab: nothing to hand out, every free rejected
    task automatic test_header_covers_slab();
        apply_setting(12, 4, 255);
        send_request(ACT_INIT, 20'd0);
        send_request(ACT_FREE, 20'd12288);
        send_request(ACT_ALLOC, 20'd0);
    endtask

    // random traffic over a series of slab settings, each opened by an init
    task automatic test_random_traffic(int sender_idle, int receiver_stall,
                                       int segments, int per_segment);
        int seg;
        int n;
        int unsigned shift;
        int unsigned count;
        int unsigned rsv;
        req_idle_pct = sender_idle;
        rsp_stall_pct = receiver_stall;
        for (seg = 0; seg < segments; seg++)
        begin
            pick_slab_setting(settings_applied - 2, shift, count, rsv);
            apply_setting(shift, count, rsv);
            send_request(ACT_INIT, 20'($urandom));
            for (n = 0; n < per_segment; n++)
                issue_random_request();
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        int n;
        apply_setting(2, 12, 1);
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        send_request(ACT_INIT, 20'd0);
        hold_req = 1'b1;
        for (n = 0; n < 30; n++)
            issue_random_request();
    endtask

    // response ready, random stalls plus one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // response checking against the oldest prediction
    always @(posedge clk)
    begin
        slab_response_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            responses_seen++;
            if (awaited_responses.size() == 0)
            begin
                $display("%0t ns: response with no request outstanding, status %0h offset %0h",
                         $time, rsp_ch.status, rsp_ch.alloc_offset);
                fault_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                check_field("status", 20'(want.status), 20'(rsp_ch.status));
                check_field("alloc_offset", want.alloc_offset, rsp_ch.alloc_offset);
                check_field("free_total", 20'(want.free_total), 20'(rsp_ch.free_total));
                check_field("slab_empty", 20'(want.slab_empty), 20'(rsp_ch.slab_empty));
                check_field("slab_full", 20'(want.slab_full), 20'(rsp_ch.slab_full));
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles, %0d responses outstanding",
                 $time, cycle_count, awaited_responses.size());
        $display("CHECK FAILED");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_INIT;
        req_ch.free_offset = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CHUNK_SHIFT;
        cfg_ch.data = '0;
        hold_req = 1'b0;
        fault_count = 0;
        responses_seen = 0;
        settings_applied = 0;
        action_tally = '{default: 0};
        reg_shift = RST_CHUNK_SHIFT;
        reg_count = RST_CHUNK_COUNT;
        reg_reserved = RST_RESERVED_CHUNKS;
        head_chunk = 8'd0;
        chunks_free = 9'd0;
        next_free = '{default: 8'd0};
        req_idle_pct = 25;
        rsp_stall_pct = 79;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_init_and_recycle();
        test_tiny_slab();
        test_header_covers_slab();
        test_random_traffic(25, 79, 7, 95);
        test_random_traffic(79, 25, 7, 95);
        test_random_traffic(0, 0, 7, 95);
        test_output_backpressure();

        wait_drained();
        repeat (END_PAUSE) @(posedge clk);
        $display("covered %0d requests: %0d init, %0d alloc, %0d free, %0d unused action",
                 action_tally[0] + action_tally[1] + action_tally[2] + action_tally[3],
                 action_tally[ACT_INIT], action_tally[ACT_ALLOC], action_tally[ACT_FREE],
                 action_tally[ACT_UNUSED]);
        $display("%0d slab settings, %0d responses compared, %0d mismatches",
                 settings_applied, responses_seen, fault_count);
        if (fault_count == 0 && awaited_responses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
